FILE: sv/uvs_pkg.sv
// ============================================================================
// UV sphere vertex package
// Widths, register codes, sine polynomial coefficients and the rounding
// helper shared by the UV sphere strip vertex generator.
// ============================================================================
`default_nettype none

package uvs_pkg;

    localparam int CNT_W   = 7;
    localparam int RAD_W   = 16;
    localparam int POS_W   = 24;
    localparam int TEX_W   = 17;
    localparam int PHASE_W = 16;

    localparam int DIVN_W  = 24;
    localparam int DIVD_W  = 8;
    localparam int DIVQ_W  = 17;

    localparam int SIN_LAT = 8;

    localparam int MAX_RINGS_DEF     = 64;
    localparam int MAX_MERIDIANS_DEF = 64;

    localparam logic [CNT_W-1:0] RING_RESET     = 7'd50;
    localparam logic [CNT_W-1:0] MERIDIAN_RESET = 7'd50;
    localparam logic [RAD_W-1:0] RADIUS_RESET   = 16'd1792;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_RING     = 2'd0;
    localparam logic [1:0] REG_MERIDIAN = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    localparam int XY_SHIFT = 23;
    localparam int Z_SHIFT  = 8;

    typedef logic signed [16:0] q15_t;

    // Coefficient added at Horner step h, from the x^7 term down to x^1.
    function automatic logic [30:0] sin_coef(input int h);
        logic [30:0] c;
        case (h)
            0:       c = SIN_C7;
            1:       c = SIN_C5;
            2:       c = SIN_C3;
            default: c = SIN_C1;
        endcase
        return c;
    endfunction

    // Shift right with rounding half away from zero, then saturate to 24 bits.
    function automatic logic [POS_W-1:0] round_sat(input logic signed [51:0] v,
                                                   input int sh);
        logic        neg;
        logic [51:0] mag;
        logic [51:0] rnd;
        neg = v[51];
        mag = neg ? 52'(-v) : 52'(v);
        rnd = (mag + (52'd1 << (sh - 1))) >> sh;
        if (!neg && rnd > 52'd8388607)
            rnd = 52'd8388607;
        if (neg && rnd > 52'd8388608)
            rnd = 52'd8388608;
        return neg ? POS_W'(-rnd) : POS_W'(rnd);
    endfunction

endpackage

`default_nettype wire

FILE: sv/uvs_in_if.sv
// ============================================================================
// Grid point channel
// Carries one ring and meridian index pair per word.
// ============================================================================
`default_nettype none

interface uvs_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] ring_index;
    logic [6:0] meridian_index;

    modport source (output valid, ring_index, meridian_index, input ready);
    modport sink   (input valid, ring_index, meridian_index, output ready);
endinterface

`default_nettype wire

FILE: sv/uvs_out_if.sv
// ============================================================================
// Vertex pair channel
// Carries the upper and lower strip vertices of one grid point per word.
// ============================================================================
`default_nettype none

interface uvs_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] upper_x;
    logic [23:0] upper_y;
    logic [23:0] upper_z;
    logic [16:0] upper_u;
    logic [23:0] lower_x;
    logic [23:0] lower_y;
    logic [23:0] lower_z;
    logic [16:0] lower_u;
    logic [16:0] shared_v;

    modport source (output valid, upper_x, upper_y, upper_z, upper_u,
                    lower_x, lower_y, lower_z, lower_u, shared_v, input ready);
    modport sink   (input valid, upper_x, upper_y, upper_z, upper_u,
                    lower_x, lower_y, lower_z, lower_u, shared_v, output ready);
endinterface

`default_nettype wire

FILE: sv/uv_sphere_strip_vertex_generator.sv
// ============================================================================
// UV sphere strip vertex generator
// Turns a ring and meridian index pair into the two strip vertices of a UV
// sphere with positions in Q8.15 and texture coordinates in Q1.16.
// ============================================================================
// Throughput: one word per cycle; the whole pipeline holds while a finished
// vertex word waits, so the output register is also the stall point.
// The latency comes from the dividend register, the 17-stage quotient
// dividers, the 8-stage sine and the product and rounding registers.
// Reset clears the pipeline valid bits and loads ring_count 50,
// meridian_count 50 and sphere_radius 1792 (7.0).
`default_nettype none

module uv_sphere_strip_vertex_generator #(
    parameter int MAX_RINGS     = uvs_pkg::MAX_RINGS_DEF,
    parameter int MAX_MERIDIANS = uvs_pkg::MAX_MERIDIANS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uvs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [uvs_pkg::APB_DW-1:0]   pwdata,
    output logic      [uvs_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    uvs_in_if.sink                            grid,
    uvs_out_if.source                         vertex
);

    localparam int CW  = uvs_pkg::CNT_W;
    localparam int NW  = uvs_pkg::DIVN_W;
    localparam int DW  = uvs_pkg::DIVD_W;
    localparam int QW  = uvs_pkg::DIVQ_W;
    localparam int TW  = uvs_pkg::TEX_W;
    localparam int PW  = uvs_pkg::PHASE_W;
    localparam int DLY = uvs_pkg::SIN_LAT + 2;
    localparam int LAT = 1 + QW + uvs_pkg::SIN_LAT + 3;
    localparam logic [PW-1:0] QUARTER = PW'(1 << (PW - 2));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]             ring_count_reg;
    logic [CW-1:0]             meridian_count_reg;
    logic [uvs_pkg::RAD_W-1:0] sphere_radius_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg     <= uvs_pkg::RING_RESET;
            meridian_count_reg <= uvs_pkg::MERIDIAN_RESET;
            sphere_radius_reg  <= uvs_pkg::RADIUS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                uvs_pkg::REG_RING:     ring_count_reg     <= pwdata[CW-1:0];
                uvs_pkg::REG_MERIDIAN: meridian_count_reg <= pwdata[CW-1:0];
                uvs_pkg::REG_RADIUS:   sphere_radius_reg  <= pwdata[uvs_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            uvs_pkg::REG_RING:     prdata = 32'(ring_count_reg);
            uvs_pkg::REG_MERIDIAN: prdata = 32'(meridian_count_reg);
            uvs_pkg::REG_RADIUS:   prdata = 32'(sphere_radius_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic       vld_reg [LAT];
    logic       en;

    assign en         = !vld_reg[LAT-1] || vertex.ready;
    assign grid.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= grid.valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Index clamping and dividend setup
    // ------------------------------------------------------------------
    logic [CW-1:0] r_eff, m_eff, i_eff, j_eff, im1;
    logic [NW-1:0] th0_reg, th1_reg, u0_reg, u1_reg, v_reg;
    logic [DW-1:0] dr_reg, dm_reg;

    always_comb
    begin
        r_eff = ring_count_reg;
        if (r_eff == '0)
            r_eff = CW'(1);
        else if (int'(r_eff) > MAX_RINGS)
            r_eff = CW'(MAX_RINGS);
        m_eff = meridian_count_reg;
        if (m_eff == '0)
            m_eff = CW'(1);
        else if (int'(m_eff) > MAX_MERIDIANS)
            m_eff = CW'(MAX_MERIDIANS);
        i_eff = grid.ring_index;
        if (i_eff == '0)
            i_eff = CW'(1);
        if (i_eff > r_eff)
            i_eff = r_eff;
        j_eff = grid.meridian_index;
        if (j_eff > m_eff)
            j_eff = m_eff;
        im1 = i_eff - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th0_reg <= NW'({im1, 16'h0000}) + NW'(r_eff);
            th1_reg <= NW'({i_eff, 16'h0000}) + NW'(r_eff);
            u0_reg  <= NW'({im1, 17'h00000}) + NW'(r_eff);
            u1_reg  <= NW'({i_eff, 17'h00000}) + NW'(r_eff);
            v_reg   <= NW'({j_eff, 17'h00000}) + NW'(m_eff);
            dr_reg  <= {r_eff, 1'b0};
            dm_reg  <= {m_eff, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Dividers
    // ------------------------------------------------------------------
    logic [QW-1:0] th0_q, th1_q, u0_q, u1_q, v_q;

    uvs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_th0 (
        .clk(clk), .en(en), .dividend(th0_reg), .divisor(dr_reg), .quotient(th0_q));
    uvs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_th1 (
        .clk(clk), .en(en), .dividend(th1_reg), .divisor(dr_reg), .quotient(th1_q));
    uvs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_u0 (
        .clk(clk), .en(en), .dividend(u0_reg), .divisor(dr_reg), .quotient(u0_q));
    uvs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_u1 (
        .clk(clk), .en(en), .dividend(u1_reg), .divisor(dr_reg), .quotient(u1_q));
    uvs_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_v (
        .clk(clk), .en(en), .dividend(v_reg), .divisor(dm_reg), .quotient(v_q));

    // ------------------------------------------------------------------
    // Sines and cosines; a cosine is the sine a quarter turn ahead.
    // ------------------------------------------------------------------
    uvs_pkg::q15_t cphi, sphi, st0, ct0, st1, ct1;

    uvs_sine u_sin_phi (.clk(clk), .en(en), .phase(v_q[PW-1:0]), .sine(sphi));
    uvs_sine u_cos_phi (.clk(clk), .en(en), .phase(v_q[PW-1:0] + QUARTER), .sine(cphi));
    uvs_sine u_sin_th0 (.clk(clk), .en(en), .phase(th0_q[PW-1:0]), .sine(st0));
    uvs_sine u_cos_th0 (.clk(clk), .en(en), .phase(th0_q[PW-1:0] + QUARTER), .sine(ct0));
    uvs_sine u_sin_th1 (.clk(clk), .en(en), .phase(th1_q[PW-1:0]), .sine(st1));
    uvs_sine u_cos_th1 (.clk(clk), .en(en), .phase(th1_q[PW-1:0] + QUARTER), .sine(ct1));

    // Texture coordinates ride alongside the sine and product stages.
    logic [TW-1:0] u0_dly_reg [DLY];
    logic [TW-1:0] u1_dly_reg [DLY];
    logic [TW-1:0] v_dly_reg  [DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u0_dly_reg[0] <= u0_q;
            u1_dly_reg[0] <= u1_q;
            v_dly_reg[0]  <= v_q;
            for (int k = 1; k < DLY; k++)
            begin
                u0_dly_reg[k] <= u0_dly_reg[k-1];
                u1_dly_reg[k] <= u1_dly_reg[k-1];
                v_dly_reg[k]  <= v_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Position products and rounding
    // ------------------------------------------------------------------
    logic signed [33:0] px0_reg, py0_reg, px1_reg, py1_reg;
    uvs_pkg::q15_t      ct0_reg, ct1_reg;
    logic signed [50:0] mx0_reg, my0_reg, mx1_reg, my1_reg;
    logic signed [33:0] mz0_reg, mz1_reg;
    logic signed [16:0] rad_s;

    logic [23:0] ux_reg, uy_reg, uz_reg, lx_reg, ly_reg, lz_reg;
    logic [TW-1:0] uu_reg, lu_reg, sv_reg;

    assign rad_s = $signed({1'b0, sphere_radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px0_reg <= cphi * st0;
            py0_reg <= sphi * st0;
            px1_reg <= cphi * st1;
            py1_reg <= sphi * st1;
            ct0_reg <= ct0;
            ct1_reg <= ct1;

            mx0_reg <= rad_s * px0_reg;
            my0_reg <= rad_s * py0_reg;
            mx1_reg <= rad_s * px1_reg;
            my1_reg <= rad_s * py1_reg;
            mz0_reg <= rad_s * ct0_reg;
            mz1_reg <= rad_s * ct1_reg;

            ux_reg <= uvs_pkg::round_sat(52'(mx0_reg), uvs_pkg::XY_SHIFT);
            uy_reg <= uvs_pkg::round_sat(52'(my0_reg), uvs_pkg::XY_SHIFT);
            uz_reg <= uvs_pkg::round_sat(52'(mz0_reg), uvs_pkg::Z_SHIFT);
            lx_reg <= uvs_pkg::round_sat(52'(mx1_reg), uvs_pkg::XY_SHIFT);
            ly_reg <= uvs_pkg::round_sat(52'(my1_reg), uvs_pkg::XY_SHIFT);
            lz_reg <= uvs_pkg::round_sat(52'(mz1_reg), uvs_pkg::Z_SHIFT);
            uu_reg <= u0_dly_reg[DLY-1];
            lu_reg <= u1_dly_reg[DLY-1];
            sv_reg <= v_dly_reg[DLY-1];
        end
    end

    assign vertex.valid    = vld_reg[LAT-1];
    assign vertex.upper_x  = ux_reg;
    assign vertex.upper_y  = uy_reg;
    assign vertex.upper_z  = uz_reg;
    assign vertex.upper_u  = uu_reg;
    assign vertex.lower_x  = lx_reg;
    assign vertex.lower_y  = ly_reg;
    assign vertex.lower_z  = lz_reg;
    assign vertex.lower_u  = lu_reg;
    assign vertex.shared_v = sv_reg;

endmodule

`default_nettype wire

FILE: sv/uvs_div.sv
// ============================================================================
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module uvs_div #(
    parameter int NW = uvs_pkg::DIVN_W,
    parameter int DW = uvs_pkg::DIVD_W,
    parameter int QW = uvs_pkg::DIVQ_W
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [QW-1:0] quotient
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] d_reg   [QW];

    // The quotient is known to fit QW bits, so the top dividend bits already
    // sit below the divisor and seed the remainder.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW-1:0] rem_src;
        logic [DW-1:0] d_src;
        logic [QW-1:0] lo_src;
        logic [QW-1:0] q_src;
        logic [DW:0]   trial;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign rem_src = DW'(dividend[NW-1:QW]);
            assign lo_src  = dividend[QW-1:0];
            assign q_src   = '0;
            assign d_src   = divisor;
        end
        else
        begin : g_later
            assign rem_src = rem_reg[s-1];
            assign lo_src  = lo_reg[s-1];
            assign q_src   = q_reg[s-1];
            assign d_src   = d_reg[s-1];
        end

        assign trial = {rem_src, lo_src[QW-1-s]};
        assign ge    = trial >= {1'b0, d_src};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? DW'(trial - {1'b0, d_src}) : DW'(trial);
                lo_reg[s]  <= lo_src;
                q_reg[s]   <= {q_src[QW-2:0], ge};
                d_reg[s]   <= d_src;
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

`default_nettype wire

FILE: sv/uvs_sine.sv
// ============================================================================
// Pipelined sine
// Quarter-wave fold, odd polynomial in Q30 by Horner steps, Q1.15 result.
// ============================================================================
`default_nettype none

module uvs_sine (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [uvs_pkg::PHASE_W-1:0]   phase,
    output uvs_pkg::q15_t                      sine
);

    localparam int HSTEPS = 4;

    logic [14:0]   x1_reg;
    logic          neg1_reg;
    logic [30:0]   x2_reg;
    logic [14:0]   x2x_reg;
    logic          neg2_reg;
    logic [30:0]   t_reg   [HSTEPS];
    logic [30:0]   tx2_reg [HSTEPS];
    logic [14:0]   tx_reg  [HSTEPS];
    logic          tneg_reg[HSTEPS];
    logic [31:0]   s_reg;
    logic          sneg_reg;
    uvs_pkg::q15_t sine_reg;

    logic [14:0] x_fold;
    logic [45:0] s_prod;
    logic [31:0] s_clamp;
    logic [15:0] s_mag;

    // Odd quadrants run the quarter wave backward; the upper half negates.
    assign x_fold = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x_fold;
            neg1_reg <= phase[15];
            x2_reg   <= {29'(x1_reg) * 29'(x1_reg), 2'b00};
            x2x_reg  <= x1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    for (genvar h = 0; h < HSTEPS; h++)
    begin : g_horner
        logic [30:0] t_src;
        logic [30:0] x2_src;
        logic [14:0] x_src;
        logic        neg_src;
        logic [61:0] prod;

        if (h == 0)
        begin : g_first
            assign t_src   = uvs_pkg::SIN_C9;
            assign x2_src  = x2_reg;
            assign x_src   = x2x_reg;
            assign neg_src = neg2_reg;
        end
        else
        begin : g_later
            assign t_src   = t_reg[h-1];
            assign x2_src  = tx2_reg[h-1];
            assign x_src   = tx_reg[h-1];
            assign neg_src = tneg_reg[h-1];
        end

        assign prod = x2_src * t_src;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[h]    <= uvs_pkg::sin_coef(h) - prod[60:30];
                tx2_reg[h]  <= x2_src;
                tx_reg[h]   <= x_src;
                tneg_reg[h] <= neg_src;
            end
        end
    end

    assign s_prod  = tx_reg[HSTEPS-1] * t_reg[HSTEPS-1];
    assign s_clamp = (s_reg > uvs_pkg::ONE_Q30) ? uvs_pkg::ONE_Q30 : s_reg;
    assign s_mag   = 16'((33'(s_clamp) + 33'd16384) >> 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= 32'(s_prod >> 14);
            sneg_reg <= tneg_reg[HSTEPS-1];
            sine_reg <= sneg_reg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

FILE: sv/uvs_checker.sv
// ============================================================================
// UV sphere vertex checker
// Port-level properties of the vertex generator, bound to the top level.
// ============================================================================
`default_nettype none

module uvs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] upper_x,
    input wire logic [16:0] upper_u,
    input wire logic [16:0] lower_u,
    input wire logic [16:0] shared_v
);

    // A word that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("vertex word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(upper_x) && $stable(shared_v))
        else $error("vertex word changed while stalled");

    // The input side only backs up behind a waiting vertex word.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("grid side stalled without a waiting vertex word");

    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shared_v <= 17'd65536)
        else $error("texture v above one");

    // The lower edge is one band further from the top pole.
    a_u_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> upper_u <= lower_u)
        else $error("upper u past lower u");

endmodule

bind uv_sphere_strip_vertex_generator uvs_checker u_uvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (grid.ready),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .upper_x   (vertex.upper_x),
    .upper_u   (vertex.upper_u),
    .lower_u   (vertex.lower_u),
    .shared_v  (vertex.shared_v)
);

`default_nettype wire
